// File: rtl/core/arm_ik_pkg.sv
// Shared constants, tables and types for the arm inverse kinematics pipeline.
`timescale 1ns / 1ps

package arm_ik_pkg;

   // Field widths
   localparam int COORD_W    = 16;
   localparam int ANGLE_W    = 16;
   localparam int LEN_W      = 15;
   localparam int ULA_W      = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;

   // Angle format: Q.30 internally, ANGLE_FRAC_BITS at the ports
   localparam int ANGLE_FRAC_BITS = 12;
   localparam int Q30_SHIFT       = 30 - ANGLE_FRAC_BITS;

   // CORDIC vectoring unit
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_TAB_LEN  = 24;
   localparam int CORDIC_ITERS  = (CORDIC_STAGES < ATAN_TAB_LEN) ? CORDIC_STAGES : ATAN_TAB_LEN;
   localparam int CRD_IN_W      = 34;
   localparam int CRD_W         = 44;
   localparam int CRD_Z_W       = 34;
   localparam int CRD_NORM_MSB  = 39;
   localparam int CRD_SHIFT_W   = 6;
   localparam int CRD_LAT       = 4 + CORDIC_ITERS;

   // Pipelined integer square root
   localparam int ISQ_IN_W  = 34;
   localparam int ISQ_STEPS = ISQ_IN_W / 2;
   localparam int ISQ_OUT_W = ISQ_STEPS;
   localparam int ISQ_LAT   = ISQ_STEPS;

   // pi/2 in Q.30, true value for quadrant folding and the 3.1415-based one for the elbow
   localparam int TRUE_HALF_PI_Q30 = 1686629713;
   localparam int FILE_HALF_PI_Q30 = 1686579970;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_HEIGHT       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LINK_LENGTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LINK_ANGLE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FOREARM_LENGTH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOOL_REACH        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MARKER_HEIGHT     = 3'd5;

   // atan(2^-i) in Q.30
   localparam logic [31:0] ATAN_TAB [ATAN_TAB_LEN] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
      32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
      32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
      32'd1024,      32'd512,       32'd256,       32'd128
   };

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;

endpackage

// File: rtl/core/arm_inverse_kinematics_4r.sv
// Top level: four-joint arm inverse kinematics pipeline with configuration registers.
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_target_x, req_target_y, req_target_z
// rsp      out        rsp_valid/rsp_stall   rsp_base_angle .. rsp_wrist_angle, rsp_unreachable
// csr      in         csr_we                csr_index, csr_wdata
//
// One item is accepted per cycle while req_stall is low.
// The datapath is a chain of a 17-stage square root, a 17-stage divider, a second
// 17-stage square root and one 20-stage CORDIC unit in series.
// Reset is synchronous and active high; it empties the pipeline and loads register defaults.
// A held result moves into a one-entry skid stage; req_stall rises only when that stage is full,
// and then the whole pipeline holds.

module arm_inverse_kinematics_4r (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  arm_ik_pkg::coord_type                  req_target_x,
   input  arm_ik_pkg::coord_type                  req_target_y,
   input  arm_ik_pkg::coord_type                  req_target_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output arm_ik_pkg::angle_type                  rsp_base_angle,
   output arm_ik_pkg::angle_type                  rsp_shoulder_angle,
   output arm_ik_pkg::angle_type                  rsp_elbow_angle,
   output arm_ik_pkg::angle_type                  rsp_wrist_angle,
   output logic                                   rsp_unreachable,
   input  logic                                   csr_we,
   input  logic [arm_ik_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [arm_ik_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import arm_ik_pkg::*;

   // Widths of the internal datapath
   localparam int REACH_W = 18;
   localparam int SQ2_W   = 36;
   localparam int NUM_W   = 37;
   localparam int AN_W    = 35;
   localparam int COS_FRAC  = 16;
   localparam int DIV_STEPS = COS_FRAC + 1;
   localparam int REM_W   = AN_W + COS_FRAC;
   localparam int COS_W   = COS_FRAC + 2;
   localparam int ANG_W   = 38;
   localparam int ANGLE_MAX = 2 ** (ANGLE_W - 1) - 1;
   localparam int ANGLE_MIN = -(2 ** (ANGLE_W - 1));

   // Stage numbers, counted in edges after acceptance
   localparam int ST_IN   = 1;
   localparam int ST_YR   = 2;
   localparam int ST_SUM  = 3;
   localparam int ST_R    = ST_SUM + ISQ_LAT;
   localparam int ST_XR   = ST_R + 1;
   localparam int ST_BASE = ST_IN + CRD_LAT;
   localparam int ST_DIV0 = ST_XR + 3;
   localparam int ST_DIVQ = ST_DIV0 + DIV_STEPS;
   localparam int ST_C    = ST_DIVQ + 1;
   localparam int ST_SV   = ST_C + 2;
   localparam int ST_S    = ST_SV + ISQ_LAT;
   localparam int ST_BIN  = ST_S + 2;
   localparam int ST_ANG  = ST_BIN + CRD_LAT;
   localparam int ST_OUT  = ST_ANG + 3;

   // Delay line lengths
   localparam int YR_LEN   = ST_BIN - ST_YR;
   localparam int XR_LEN   = ST_BIN - ST_XR;
   localparam int C_LEN    = ST_S - ST_C;
   localparam int BASE_LEN = ST_ANG - ST_BASE;
   localparam int UNR_LEN  = ST_ANG - ST_C;

   typedef struct packed {
      angle_type base;
      angle_type shoulder;
      angle_type elbow;
      angle_type wrist;
      logic      unreachable;
   } rsp_type;

   function automatic angle_type angle_out(input logic signed [ANG_W-1:0] v);
      logic signed [ANG_W-1:0] t;
      t = (v + ANG_W'(1 << (Q30_SHIFT - 1))) >>> Q30_SHIFT;
      if (t > ANG_W'(ANGLE_MAX)) return ANGLE_W'(ANGLE_MAX);
      if (t < ANG_W'(ANGLE_MIN)) return ANGLE_W'(ANGLE_MIN);
      return t[ANGLE_W-1:0];
   endfunction

   // Configuration registers and their derived products
   logic [LEN_W-1:0] base_height_ff, upper_link_length_ff, forearm_length_ff;
   logic [LEN_W-1:0] tool_reach_ff, marker_height_ff;
   logic [ULA_W-1:0] upper_link_angle_ff;
   logic [2*LEN_W-1:0] l2sq_ff, l3sq_ff, l23_ff;
   logic [2*LEN_W:0]   lsum_ff, den_ff;

   // Pipeline control
   logic [ST_OUT:1] v_ff;
   logic            adv;
   logic            rsp_valid_ff, skid_v_ff;
   rsp_type         out_ff, rsp_ff, skid_ff;

   // Datapath registers
   coord_type                   x_ff, y_ff, z_ff;
   logic signed [2*COORD_W-1:0] xx_ff, yy_ff;
   logic signed [REACH_W-1:0]   yr_ff, yr_in;
   logic [2*COORD_W-1:0]        sq_ff;
   logic [ISQ_OUT_W-1:0]        r_root, s_root;
   logic signed [REACH_W-1:0]   xr_ff;
   logic signed [REACH_W-1:0]   yr_dl_ff [YR_LEN];
   logic signed [REACH_W-1:0]   xr_dl_ff [XR_LEN];
   logic signed [SQ2_W-1:0]     xr2_ff, yr2_ff;
   logic signed [NUM_W-1:0]     num_ff;
   logic [AN_W-1:0]             an_in;
   logic [REM_W-1:0]            rem_ff [DIV_STEPS+1];
   logic [REM_W-1:0]            rem_in [DIV_STEPS];
   logic [DIV_STEPS-1:0]        q_ff   [DIV_STEPS+1];
   logic [DIV_STEPS-1:0]        q_in   [DIV_STEPS];
   logic                        neg_ff [DIV_STEPS+1];
   logic                        big_ff [DIV_STEPS+1];
   logic signed [COS_W-1:0]     c_ff, c_in;
   logic                        unr_ff, unr_in;
   logic signed [COS_W-1:0]     c_dl_ff [C_LEN];
   logic                        unr_dl_ff [UNR_LEN];
   logic signed [2*COS_W-1:0]   csq_ff;
   logic [2*COS_FRAC:0]         sv_ff;
   logic [2*LEN_W+1:0]          p1_ff;
   logic signed [CRD_IN_W-1:0]  p2_ff;
   logic [ISQ_OUT_W-1:0]        s_p_ff;
   logic signed [COS_W-1:0]     c_p_ff;
   logic signed [CRD_IN_W-1:0]  by_ff, bx_ff, s_b_ff, c_b_ff;
   logic signed [CRD_Z_W-1:0]   base_z, q3_z, a_z, b_z;
   logic signed [CRD_Z_W-1:0]   base_dl_ff [BASE_LEN];
   logic signed [ANG_W-1:0]     sh_ff, el_ff, sh_w_ff, el_w_ff, wr_ff;
   logic signed [CRD_Z_W-1:0]   base_sh_ff, base_w_ff;
   logic                        unr_sh_ff, unr_w_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_height_ff       <= LEN_W'(2360);
         upper_link_length_ff <= LEN_W'(2803);
         upper_link_angle_ff  <= ULA_W'(1412);
         forearm_length_ff    <= LEN_W'(2509);
         tool_reach_ff        <= LEN_W'(2918);
         marker_height_ff     <= LEN_W'(1280);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_HEIGHT:       base_height_ff       <= csr_wdata;
            CSR_UPPER_LINK_LENGTH: upper_link_length_ff <= csr_wdata;
            CSR_UPPER_LINK_ANGLE:  upper_link_angle_ff  <= csr_wdata[ULA_W-1:0];
            CSR_FOREARM_LENGTH:    forearm_length_ff    <= csr_wdata;
            CSR_TOOL_REACH:        tool_reach_ff        <= csr_wdata;
            CSR_MARKER_HEIGHT:     marker_height_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Refresh link products from the registers
   always_ff @(posedge clock) begin
      l2sq_ff <= upper_link_length_ff * upper_link_length_ff;
      l3sq_ff <= forearm_length_ff * forearm_length_ff;
      l23_ff  <= upper_link_length_ff * forearm_length_ff;
      lsum_ff <= (2*LEN_W+1)'(l2sq_ff) + (2*LEN_W+1)'(l3sq_ff);
      den_ff  <= {l23_ff, 1'b0};
   end

   // Hold the pipeline only while the skid stage is occupied
   assign adv       = !skid_v_ff;
   assign req_stall = !adv;

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[ST_OUT-1:1], req_valid};
      end
   end

   // Base angle and planar reach front end
   assign yr_in = REACH_W'(z_ff) + $signed({3'b0, marker_height_ff})
                  - $signed({3'b0, base_height_ff});

   arm_ik_cordic u_base_cordic (
      .clock  (clock),
      .enable (adv),
      .in_y   (CRD_IN_W'(y_ff)),
      .in_x   (CRD_IN_W'(x_ff)),
      .angle  (base_z)
   );

   arm_ik_isqrt u_reach_isqrt (
      .clock  (clock),
      .enable (adv),
      .value  (ISQ_IN_W'(sq_ff)),
      .root   (r_root)
   );

   // Divider setup magnitude
   assign an_in = num_ff[NUM_W-1] ? AN_W'(-num_ff) : AN_W'(num_ff);

   // Restoring division of |num| * 2^16 by twice the link product, one quotient bit per stage
   always_comb begin
      logic [REM_W-1:0] dsh;
      for (int j = 0; j < DIV_STEPS; j++) begin
         dsh = REM_W'(den_ff) << (DIV_STEPS - 1 - j);
         if (rem_ff[j] >= dsh) begin
            rem_in[j] = rem_ff[j] - dsh;
            q_in[j]   = q_ff[j] | (DIV_STEPS'(1) << (DIV_STEPS - 1 - j));
         end else begin
            rem_in[j] = rem_ff[j];
            q_in[j]   = q_ff[j];
         end
      end
   end

   // Clamp the elbow cosine to +/-1.0 and flag it
   always_comb begin
      logic [DIV_STEPS-1:0] mag;
      mag    = q_ff[DIV_STEPS];
      unr_in = 1'b0;
      if (den_ff == '0 || big_ff[DIV_STEPS] ||
          q_ff[DIV_STEPS] > (DIV_STEPS'(1) << COS_FRAC)) begin
         mag    = DIV_STEPS'(1) << COS_FRAC;
         unr_in = 1'b1;
      end
      c_in = neg_ff[DIV_STEPS] ? -COS_W'(mag) : COS_W'(mag);
   end

   arm_ik_isqrt u_sine_isqrt (
      .clock  (clock),
      .enable (adv),
      .value  (ISQ_IN_W'(sv_ff)),
      .root   (s_root)
   );

   // Elbow, shoulder reach and link angles
   arm_ik_cordic u_elbow_cordic (
      .clock  (clock),
      .enable (adv),
      .in_y   (s_b_ff),
      .in_x   (c_b_ff),
      .angle  (q3_z)
   );

   arm_ik_cordic u_reach_cordic (
      .clock  (clock),
      .enable (adv),
      .in_y   (CRD_IN_W'(xr_dl_ff[XR_LEN-1])),
      .in_x   (CRD_IN_W'(yr_dl_ff[YR_LEN-1])),
      .angle  (a_z)
   );

   arm_ik_cordic u_link_cordic (
      .clock  (clock),
      .enable (adv),
      .in_y   (by_ff),
      .in_x   (bx_ff),
      .angle  (b_z)
   );

   // Datapath stages, all held together by the stall
   always_ff @(posedge clock) begin
      if (adv) begin
         // accept
         x_ff <= req_target_x;
         y_ff <= req_target_y;
         z_ff <= req_target_z;
         // squares and vertical reach
         xx_ff <= x_ff * x_ff;
         yy_ff <= y_ff * y_ff;
         yr_ff <= yr_in;
         sq_ff <= (2*COORD_W)'(xx_ff) + (2*COORD_W)'(yy_ff);
         // horizontal reach
         xr_ff <= $signed({1'b0, r_root}) - $signed({3'b0, tool_reach_ff});
         xr2_ff <= xr_ff * xr_ff;
         yr2_ff <= yr_dl_ff[ST_XR-ST_YR-1] * yr_dl_ff[ST_XR-ST_YR-1];
         num_ff <= NUM_W'(xr2_ff) + NUM_W'(yr2_ff) - $signed({6'b0, lsum_ff});
         // divider
         rem_ff[0] <= REM_W'(an_in) << COS_FRAC;
         q_ff[0]   <= '0;
         neg_ff[0] <= num_ff[NUM_W-1];
         big_ff[0] <= an_in >= AN_W'({den_ff, 1'b0});
         for (int j = 0; j < DIV_STEPS; j++) begin
            rem_ff[j+1] <= rem_in[j];
            q_ff[j+1]   <= q_in[j];
            neg_ff[j+1] <= neg_ff[j];
            big_ff[j+1] <= big_ff[j];
         end
         // cosine, sine argument
         c_ff   <= c_in;
         unr_ff <= unr_in;
         csq_ff <= c_ff * c_ff;
         sv_ff  <= ((2*COS_FRAC+1)'(1) << (2*COS_FRAC)) - csq_ff[2*COS_FRAC:0];
         // link triangle operands
         p1_ff  <= forearm_length_ff * s_root;
         p2_ff  <= $signed({1'b0, forearm_length_ff}) * c_dl_ff[C_LEN-1];
         s_p_ff <= s_root;
         c_p_ff <= c_dl_ff[C_LEN-1];
         by_ff  <= $signed({2'b0, p1_ff});
         bx_ff  <= $signed({3'b0, upper_link_length_ff, COS_FRAC'(0)}) + p2_ff;
         s_b_ff <= $signed(CRD_IN_W'(s_p_ff));
         c_b_ff <= CRD_IN_W'(c_p_ff);
         // joint offsets
         sh_ff <= $signed(ANG_W'(upper_link_angle_ff) << Q30_SHIFT)
                  - (ANG_W'(a_z) - ANG_W'(b_z));
         el_ff <= ANG_W'(FILE_HALF_PI_Q30) - ANG_W'(q3_z);
         base_sh_ff <= base_dl_ff[BASE_LEN-1];
         unr_sh_ff  <= unr_dl_ff[UNR_LEN-1];
         wr_ff     <= -sh_ff - el_ff;
         sh_w_ff   <= sh_ff;
         el_w_ff   <= el_ff;
         base_w_ff <= base_sh_ff;
         unr_w_ff  <= unr_sh_ff;
         // round and saturate
         out_ff.base        <= angle_out(ANG_W'(base_w_ff));
         out_ff.shoulder    <= angle_out(sh_w_ff);
         out_ff.elbow       <= angle_out(el_w_ff);
         out_ff.wrist       <= angle_out(wr_ff);
         out_ff.unreachable <= unr_w_ff;
      end
   end

   // Alignment delay lines
   always_ff @(posedge clock) begin
      if (adv) begin
         yr_dl_ff[0]   <= yr_ff;
         xr_dl_ff[0]   <= xr_ff;
         c_dl_ff[0]    <= c_ff;
         unr_dl_ff[0]  <= unr_ff;
         base_dl_ff[0] <= base_z;
         for (int i = 1; i < YR_LEN; i++) yr_dl_ff[i] <= yr_dl_ff[i-1];
         for (int i = 1; i < XR_LEN; i++) xr_dl_ff[i] <= xr_dl_ff[i-1];
         for (int i = 1; i < C_LEN; i++) c_dl_ff[i] <= c_dl_ff[i-1];
         for (int i = 1; i < UNR_LEN; i++) unr_dl_ff[i] <= unr_dl_ff[i-1];
         for (int i = 1; i < BASE_LEN; i++) base_dl_ff[i] <= base_dl_ff[i-1];
      end
   end

   // Output register and skid stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_v_ff    <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_v_ff) begin
            rsp_valid_ff <= 1'b1;
            skid_v_ff    <= 1'b0;
         end else begin
            rsp_valid_ff <= v_ff[ST_OUT];
         end
      end else if (v_ff[ST_OUT] && adv) begin
         skid_v_ff <= 1'b1;
      end
   end

   // Output register and skid stage data
   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_ff <= skid_v_ff ? skid_ff : out_ff;
      end else if (v_ff[ST_OUT] && adv) begin
         skid_ff <= out_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_base_angle     = rsp_ff.base;
   assign rsp_shoulder_angle = rsp_ff.shoulder;
   assign rsp_elbow_angle    = rsp_ff.elbow;
   assign rsp_wrist_angle    = rsp_ff.wrist;
   assign rsp_unreachable    = rsp_ff.unreachable;

   // Skid stage is only filled behind a waiting result
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> rsp_valid_ff)
      else $error("skid stage full without a result on the output");

   // A frozen pipeline keeps its items
   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff))
      else $error("pipeline valid bits changed while held");

   // An accepted item enters the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v_ff[ST_IN])
      else $error("accepted item missing from the first stage");

   // A finished item behind a held result goes to the skid stage
   a_skid_capture: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && !skid_v_ff && v_ff[ST_OUT]) |=> skid_v_ff)
      else $error("finished item dropped behind a held result");

   // Reset empties the output side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !skid_v_ff))
      else $error("output side not empty after reset");

endmodule

// File: rtl/core/arm_ik_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module arm_ik_isqrt (
   input  logic                               clock,
   input  logic                               enable,
   input  logic [arm_ik_pkg::ISQ_IN_W-1:0]    value,
   output logic [arm_ik_pkg::ISQ_OUT_W-1:0]   root
);
   import arm_ik_pkg::*;

   localparam int RW = ISQ_IN_W + 1;

   logic [RW-1:0] rem_ff  [ISQ_STEPS];
   logic [RW-1:0] res_ff  [ISQ_STEPS];
   logic [RW-1:0] rem_src [ISQ_STEPS];
   logic [RW-1:0] res_src [ISQ_STEPS];
   logic [RW-1:0] rem_in  [ISQ_STEPS];
   logic [RW-1:0] res_in  [ISQ_STEPS];

   // Feed each stage from the one before
   always_comb begin
      rem_src[0] = RW'(value);
      res_src[0] = '0;
      for (int k = 1; k < ISQ_STEPS; k++) begin
         rem_src[k] = rem_ff[k-1];
         res_src[k] = res_ff[k-1];
      end
   end

   // Try one root bit per stage
   always_comb begin
      logic [RW-1:0] bitv;
      logic [RW-1:0] trial;
      for (int k = 0; k < ISQ_STEPS; k++) begin
         bitv  = RW'(1) << (2 * (ISQ_STEPS - 1 - k));
         trial = res_src[k] + bitv;
         if (rem_src[k] >= trial) begin
            rem_in[k] = rem_src[k] - trial;
            res_in[k] = (res_src[k] >> 1) + bitv;
         end else begin
            rem_in[k] = rem_src[k];
            res_in[k] = res_src[k] >> 1;
         end
      end
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < ISQ_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            res_ff[k] <= res_in[k];
         end
      end
   end

   assign root = res_ff[ISQ_STEPS-1][ISQ_OUT_W-1:0];

endmodule

// File: rtl/core/arm_ik_cordic.sv
// Pipelined vectoring CORDIC computing atan2(y, x) in Q.30.
`timescale 1ns / 1ps

module arm_ik_cordic (
   input  logic                                    clock,
   input  logic                                    enable,
   input  logic signed [arm_ik_pkg::CRD_IN_W-1:0]  in_y,
   input  logic signed [arm_ik_pkg::CRD_IN_W-1:0]  in_x,
   output logic signed [arm_ik_pkg::CRD_Z_W-1:0]   angle
);
   import arm_ik_pkg::*;

   // Magnitude stage
   logic signed [CRD_IN_W-1:0] x0_ff, y0_ff;
   logic [CRD_IN_W-1:0]        m0_ff;
   logic                       zero0_ff;
   // Shift count stage
   logic signed [CRD_IN_W-1:0] x1_ff, y1_ff;
   logic [CRD_SHIFT_W-1:0]     k1_ff;
   logic                       zero1_ff;
   // Normalized stage
   logic signed [CRD_W-1:0]    x2_ff, y2_ff;
   logic                       zero2_ff;
   // Pre-rotation and iterations
   logic signed [CRD_W-1:0]    xi_ff [CORDIC_ITERS+1];
   logic signed [CRD_W-1:0]    yi_ff [CORDIC_ITERS+1];
   logic signed [CRD_Z_W-1:0]  zi_ff [CORDIC_ITERS+1];
   logic                       zf_ff [CORDIC_ITERS+1];

   logic [CRD_IN_W-1:0]        ax_in, ay_in;
   logic [CRD_SHIFT_W-1:0]     k_in;
   logic signed [CRD_W-1:0]    xp_in, yp_in;
   logic signed [CRD_Z_W-1:0]  zp_in;
   logic signed [CRD_W-1:0]    xi_in [CORDIC_ITERS];
   logic signed [CRD_W-1:0]    yi_in [CORDIC_ITERS];
   logic signed [CRD_Z_W-1:0]  zi_in [CORDIC_ITERS];

   // Take magnitudes
   assign ax_in = in_x[CRD_IN_W-1] ? CRD_IN_W'(-in_x) : CRD_IN_W'(in_x);
   assign ay_in = in_y[CRD_IN_W-1] ? CRD_IN_W'(-in_y) : CRD_IN_W'(in_y);

   // Find the shift that brings the larger magnitude up to the normalized range
   always_comb begin
      int msb;
      msb = 0;
      for (int i = 0; i < CRD_IN_W; i++) begin
         if (m0_ff[i]) msb = i;
      end
      k_in = CRD_SHIFT_W'(CRD_NORM_MSB - msb);
   end

   // Fold the left half plane onto the right by a quarter turn
   always_comb begin
      xp_in = x2_ff;
      yp_in = y2_ff;
      zp_in = '0;
      if (x2_ff < 0) begin
         if (y2_ff >= 0) begin
            xp_in = y2_ff;
            yp_in = -x2_ff;
            zp_in = CRD_Z_W'(TRUE_HALF_PI_Q30);
         end else begin
            xp_in = -y2_ff;
            yp_in = x2_ff;
            zp_in = -CRD_Z_W'(TRUE_HALF_PI_Q30);
         end
      end
   end

   // Micro-rotations, one per stage
   always_comb begin
      logic signed [CRD_Z_W-1:0] step;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         step = $signed(CRD_Z_W'(ATAN_TAB[i]));
         if (yi_ff[i] > 0) begin
            xi_in[i] = xi_ff[i] + (yi_ff[i] >>> i);
            yi_in[i] = yi_ff[i] - (xi_ff[i] >>> i);
            zi_in[i] = zi_ff[i] + step;
         end else begin
            xi_in[i] = xi_ff[i] - (yi_ff[i] >>> i);
            yi_in[i] = yi_ff[i] + (xi_ff[i] >>> i);
            zi_in[i] = zi_ff[i] - step;
         end
      end
   end

   // Advance the pipeline
   always_ff @(posedge clock) begin
      if (enable) begin
         x0_ff    <= in_x;
         y0_ff    <= in_y;
         m0_ff    <= (ax_in > ay_in) ? ax_in : ay_in;
         zero0_ff <= (in_x == 0) && (in_y == 0);

         x1_ff    <= x0_ff;
         y1_ff    <= y0_ff;
         k1_ff    <= k_in;
         zero1_ff <= zero0_ff;

         x2_ff    <= CRD_W'(x1_ff) <<< k1_ff;
         y2_ff    <= CRD_W'(y1_ff) <<< k1_ff;
         zero2_ff <= zero1_ff;

         xi_ff[0] <= xp_in;
         yi_ff[0] <= yp_in;
         zi_ff[0] <= zp_in;
         zf_ff[0] <= zero2_ff;
         for (int i = 0; i < CORDIC_ITERS; i++) begin
            xi_ff[i+1] <= xi_in[i];
            yi_ff[i+1] <= yi_in[i];
            zi_ff[i+1] <= zi_in[i];
            zf_ff[i+1] <= zf_ff[i];
         end
      end
   end

   // atan2 of the origin is zero
   assign angle = zf_ff[CORDIC_ITERS] ? '0 : zi_ff[CORDIC_ITERS];

endmodule
